// File: design/pdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_pkg: shared types, constants and microcode for the prime digit classifier
// Holds the control word layout and the program ROM that the sequencer steps
// through, plus the datapath widths and the decimal limits.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int unsigned VALUE_LIMIT = 100000;
    localparam int unsigned CAND_W      = 17;
    // Divisor reaches at most one above the integer square root of VALUE_LIMIT-1
    localparam int unsigned DIV_W       = 9;
    localparam int unsigned STEP_W      = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned PC_W        = 4;
    // Divide by ten as a multiply by ceil(2^23 / 10) and a shift by 23;
    // exact for every value below 2^22
    localparam int unsigned RECIP_W     = 20;
    localparam int unsigned RECIP_SHIFT = 23;

    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CAND_W - 1);
    localparam logic [CAND_W-1:0]  LIMIT_V   = CAND_W'(VALUE_LIMIT);
    localparam logic [RECIP_W-1:0] DIG_RECIP = RECIP_W'(838861);

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_NOP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_NEXT_D,
        OP_EMIT,
        OP_DIG_INIT,
        OP_DIG_DIV,
        OP_DIG_ACC,
        OP_FLAGS
    } t_op;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_TRIVIAL,
        CND_SQ_OVER,
        CND_DIV_MORE,
        CND_REM_NZ,
        CND_QUO_NZ,
        CND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // Datapath status seen by the sequencer's jump logic
    typedef struct packed {
        logic in_valid;
        logic trivial;
        logic sq_over;
        logic div_more;
        logic rem_nz;
        logic quo_nz;
        logic out_busy;
    } t_flags;

    localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_TEST  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_DIV   = PC_W'(3);
    localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_DIGIT = PC_W'(7);
    localparam logic [PC_W-1:0] PC_DSTEP = PC_W'(8);
    localparam logic [PC_W-1:0] PC_DACC  = PC_W'(9);

    // Jump to target when the condition holds, else advance one step
    function automatic t_ctrl pdc_rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            4'd0:    w = '{OP_ACCEPT,   CND_NO_INPUT, PC_IDLE};
            4'd1:    w = '{OP_NOP,      CND_TRIVIAL,  PC_EMIT};
            4'd2:    w = '{OP_DIV_INIT, CND_SQ_OVER,  PC_DIGIT};
            4'd3:    w = '{OP_DIV_STEP, CND_DIV_MORE, PC_DIV};
            4'd4:    w = '{OP_NEXT_D,   CND_REM_NZ,   PC_TEST};
            4'd5:    w = '{OP_EMIT,     CND_OUT_BUSY, PC_EMIT};
            4'd6:    w = '{OP_NOP,      CND_ALWAYS,   PC_IDLE};
            4'd7:    w = '{OP_DIG_INIT, CND_ALWAYS,   PC_DSTEP};
            4'd8:    w = '{OP_DIG_DIV,  CND_ALWAYS,   PC_DACC};
            4'd9:    w = '{OP_DIG_ACC,  CND_QUO_NZ,   PC_DSTEP};
            4'd10:   w = '{OP_FLAGS,    CND_ALWAYS,   PC_EMIT};
            default: w = '{OP_NOP,      CND_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: design/prime_digit_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_digit_classifier_unit: primality and decimal digit flags
// Trial division by a bit-serial divider under microcode control.
// ----------------------------------------------------------------------------
// One item is classified at a time; a new item is taken only once the program
// is back at its idle step. Candidates below two or at or above the value
// limit go straight to the output step. Otherwise each trial divisor from 2
// up to the integer square root takes a setup step, one step of the
// one-bit-per-cycle restoring divider per candidate bit and an advance step.
// A prime then makes the digit pass, which peels one digit per divide and
// accumulate step pair with a multiply by the reciprocal of ten. The finished
// result sits in an output register, so the next item is accepted while it
// waits.
module prime_digit_classifier_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [pdc_pkg::CAND_W-1:0]  i_candidate,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_is_prime,
    output logic                             o_palindrome,
    output logic                             o_digit_sum_odd,
    output logic [pdc_pkg::COUNT_W-1:0]      o_digit_count
);
    import pdc_pkg::*;

    t_ctrl  w_ctrl;
    t_flags w_flags;

    logic [CAND_W-1:0]  r_v,    n_v;
    logic [DIV_W-1:0]   r_d,    n_d;
    logic [CAND_W-1:0]  r_sq,   n_sq;
    logic [CAND_W-1:0]  r_quo,  n_quo;
    logic [DIV_W-1:0]   r_rem,  n_rem;
    logic [DIV_W-1:0]   r_div,  n_div;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [COUNT_W-1:0] r_cnt,  n_cnt;
    logic               r_trivial, n_trivial;
    logic               r_prime, n_prime;
    logic               r_pal,  n_pal;
    logic               r_odd,  n_odd;
    logic               r_par,  n_par;
    logic               r_first, n_first;
    logic [DIGIT_W-1:0] r_last, n_last;
    logic [DIGIT_W-1:0] r_lead, n_lead;

    logic               r_out_valid;
    logic               r_o_prime, r_o_pal, r_o_odd;
    logic [COUNT_W-1:0] r_o_cnt;

    logic [DIV_W:0]     w_rem_sh;
    logic               w_ge;
    logic [DIV_W:0]     w_rem_sub;
    logic [CAND_W+RECIP_W-1:0] w_dig_prod;
    logic [CAND_W-1:0]  w_dig_quo;
    logic [CAND_W-1:0]  w_dig_ten;
    logic [CAND_W-1:0]  w_dig_diff;
    logic [COUNT_W-1:0] w_in_cnt;
    logic               w_accept;
    logic               w_out_busy;
    logic               w_emit;

    pdc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign o_in_ready = (w_ctrl.op == OP_ACCEPT);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_out_busy = r_out_valid && !i_out_ready;
    assign w_emit     = (w_ctrl.op == OP_EMIT) && !w_out_busy;

    assign w_flags.in_valid = i_in_valid;
    assign w_flags.trivial  = r_trivial;
    assign w_flags.sq_over  = (r_sq > r_v);
    assign w_flags.div_more = (r_step != STEP_LAST);
    assign w_flags.rem_nz   = (r_rem != '0);
    assign w_flags.quo_nz   = (r_quo != '0);
    assign w_flags.out_busy = w_out_busy;

    // One restoring division step: shift in the next dividend bit
    assign w_rem_sh  = {r_rem, r_quo[CAND_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    // Quotient by ten, then the digit as what is left over
    assign w_dig_prod = {{RECIP_W{1'b0}}, r_quo} * {{CAND_W{1'b0}}, DIG_RECIP};
    assign w_dig_quo  = CAND_W'(w_dig_prod[CAND_W+RECIP_W-1:RECIP_SHIFT]);
    assign w_dig_ten  = {w_dig_quo[CAND_W-4:0], 3'b000} + {w_dig_quo[CAND_W-2:0], 1'b0};
    assign w_dig_diff = r_quo - w_dig_ten;

    always_comb begin
        priority if (i_candidate > CAND_W'(9999)) begin
            w_in_cnt = COUNT_W'(5);
        end else if (i_candidate > CAND_W'(999)) begin
            w_in_cnt = COUNT_W'(4);
        end else if (i_candidate > CAND_W'(99)) begin
            w_in_cnt = COUNT_W'(3);
        end else if (i_candidate > CAND_W'(9)) begin
            w_in_cnt = COUNT_W'(2);
        end else begin
            w_in_cnt = COUNT_W'(1);
        end
    end

    always_comb begin
        n_v       = r_v;
        n_d       = r_d;
        n_sq      = r_sq;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_div     = r_div;
        n_step    = r_step;
        n_cnt     = r_cnt;
        n_trivial = r_trivial;
        n_prime   = r_prime;
        n_pal     = r_pal;
        n_odd     = r_odd;
        n_par     = r_par;
        n_first   = r_first;
        n_last    = r_last;
        n_lead    = r_lead;
        unique case (w_ctrl.op)
            OP_ACCEPT: begin
                if (w_accept) begin
                    n_v       = i_candidate;
                    n_d       = DIV_W'(2);
                    n_sq      = CAND_W'(4);
                    n_cnt     = w_in_cnt;
                    n_trivial = (i_candidate < CAND_W'(2)) || (i_candidate >= LIMIT_V);
                    n_prime   = 1'b0;
                    n_pal     = 1'b0;
                    n_odd     = 1'b0;
                end
            end
            OP_DIV_INIT: begin
                n_quo  = r_v;
                n_rem  = '0;
                n_div  = r_d;
                n_step = '0;
            end
            OP_DIV_STEP: begin
                n_rem  = w_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
                n_quo  = {r_quo[CAND_W-2:0], w_ge};
                n_step = r_step + STEP_W'(1);
            end
            OP_NEXT_D: begin
                // (d+1)^2 = d^2 + 2d + 1
                n_d  = r_d + DIV_W'(1);
                n_sq = r_sq + {(CAND_W-DIV_W-1)'(0), r_d, 1'b1};
            end
            OP_DIG_INIT: begin
                n_prime = 1'b1;
                n_quo   = r_v;
                n_par   = 1'b0;
                n_first = 1'b1;
            end
            OP_DIG_DIV: begin
                n_quo = w_dig_quo;
                n_rem = DIV_W'(w_dig_diff[DIGIT_W-1:0]);
            end
            OP_DIG_ACC: begin
                n_par   = r_par ^ r_rem[0];
                n_lead  = r_rem[DIGIT_W-1:0];
                n_first = 1'b0;
                if (r_first) begin
                    n_last = r_rem[DIGIT_W-1:0];
                end
            end
            OP_FLAGS: begin
                n_pal = (r_cnt == COUNT_W'(1)) ||
                        (((r_cnt == COUNT_W'(2)) || (r_cnt == COUNT_W'(3))) &&
                         (r_lead == r_last));
                n_odd = (r_cnt != COUNT_W'(1)) && r_par;
            end
            OP_NOP, OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_d       <= n_d;
        r_sq      <= n_sq;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_step    <= n_step;
        r_cnt     <= n_cnt;
        r_trivial <= n_trivial;
        r_prime   <= n_prime;
        r_pal     <= n_pal;
        r_odd     <= n_odd;
        r_par     <= n_par;
        r_first   <= n_first;
        r_last    <= n_last;
        r_lead    <= n_lead;
        if (w_emit) begin
            r_o_prime <= r_prime;
            r_o_pal   <= r_pal;
            r_o_odd   <= r_odd;
            r_o_cnt   <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_prime      = r_o_prime;
    assign o_palindrome    = r_o_pal;
    assign o_digit_sum_odd = r_o_odd;
    assign o_digit_count   = r_o_cnt;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_DIV_STEP) |=> (r_rem < r_div))
        else $error("remainder not below divisor after division step");

    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_ctrl.op == OP_NEXT_D) |-> (r_sq == (CAND_W'(r_d) * CAND_W'(r_d))))
        else $error("square register out of step with divisor");

    a_flags_need_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_palindrome || o_digit_sum_odd)) |-> o_is_prime)
        else $error("digit flag raised on a non-prime");

    a_odd_multi_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_digit_sum_odd) |-> (o_digit_count != COUNT_W'(1)))
        else $error("digit sum flag on a one-digit result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_digit_count != '0) && (o_digit_count <= COUNT_W'(5))))
        else $error("digit count out of range");

endmodule
`default_nettype wire

// File: design/pdc_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_seq: microcode sequencer
// Step counter over the program ROM; picks the jump condition out of the
// datapath flags and issues one control word per cycle.
// ----------------------------------------------------------------------------
module pdc_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pdc_pkg::t_flags i_flags,
    output pdc_pkg::t_ctrl       o_ctrl
);
    import pdc_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;
    logic            w_take;

    assign w_ctrl = pdc_rom(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        unique case (w_ctrl.cond)
            CND_ALWAYS:   w_take = 1'b1;
            CND_NO_INPUT: w_take = !i_flags.in_valid;
            CND_TRIVIAL:  w_take = i_flags.trivial;
            CND_SQ_OVER:  w_take = i_flags.sq_over;
            CND_DIV_MORE: w_take = i_flags.div_more;
            CND_REM_NZ:   w_take = i_flags.rem_nz;
            CND_QUO_NZ:   w_take = i_flags.quo_nz;
            CND_OUT_BUSY: w_take = i_flags.out_busy;
            default:      w_take = 1'b0;
        endcase
        n_pc = w_take ? w_ctrl.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire
